// ----- design/apc_command_deframer_core_assert.svh -----
// Assertion shorthands for the deframer core.
// Each expects clk and arst_n in scope.
`ifndef APC_COMMAND_DEFRAMER_CORE_ASSERT_SVH
`define APC_COMMAND_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication
`define ACD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acd assertion failed");

// next-cycle implication
`define ACD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acd assertion failed");

`endif

// ----- design/acd_pkg.sv -----
package acd_pkg;

	localparam int PAYLOAD_MAX_DEF = 255;

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_APC = 8'h5F;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [23:0] PFX_PS = "PS:";
	localparam logic [23:0] PFX_CS = "CS:";
	localparam logic [31:0] PFX_NAV = "NAV:";

	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;

	typedef logic [3:0][7:0] prefix_t;

	typedef enum logic [3:0] {
		FR_IDLE    = 4'b0001,
		FR_ESC     = 4'b0010,
		FR_PAYLOAD = 4'b0100,
		FR_PESC    = 4'b1000
	} frame_phase_t;

	typedef enum logic [2:0] {
		NUM_SKIP   = 3'b001,
		NUM_DIGITS = 3'b010,
		NUM_STOP   = 3'b100
	} num_phase_t;

	typedef enum logic [1:0] {
		EV_PROMPT  = 2'd0,
		EV_COMMAND = 2'd1,
		EV_NAV     = 2'd2,
		EV_UNKNOWN = 2'd3
	} event_kind_t;

	typedef struct packed {
		logic [31:0] accum;
		logic        negative;
		num_phase_t  phase;
	} num_state_t;

	localparam num_state_t NUM_CLEAR = '{accum: 32'd0, negative: 1'b0, phase: NUM_SKIP};

	function automatic logic pfx_is_ps(prefix_t p);
		return {p[0], p[1], p[2]} == PFX_PS;
	endfunction

	function automatic logic pfx_is_cs(prefix_t p);
		return {p[0], p[1], p[2]} == PFX_CS;
	endfunction

	function automatic logic pfx_is_nav(prefix_t p);
		return {p[0], p[1], p[2], p[3]} == PFX_NAV;
	endfunction

	// one byte of atoi-style parsing, magnitude clamps at 2^31
	function automatic num_state_t parse_byte(num_state_t s, logic [7:0] b);
		num_state_t  r;
		logic [35:0] v;
		logic [7:0]  d;
		logic        go;
		r  = s;
		go = 1'b0;
		d  = b - CH_ZERO;
		v  = ({4'd0, s.accum} << 3) + ({4'd0, s.accum} << 1) + {32'd0, d[3:0]};
		case (s.phase)
			NUM_SKIP: begin
				if ((b >= CH_TAB && b <= CH_CR) || b == CH_SPACE) begin
					go = 1'b0;
				end else if (b == CH_PLUS || b == CH_MINUS) begin
					r.negative = (b == CH_MINUS);
					r.phase    = NUM_DIGITS;
				end else begin
					r.phase = NUM_DIGITS;
					go      = 1'b1;
				end
			end
			NUM_DIGITS: go = 1'b1;
			default: go = 1'b0;
		endcase
		if (go) begin
			if (b >= CH_ZERO && b <= CH_NINE) begin
				r.accum = (v > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : v[31:0];
			end else begin
				r.phase = NUM_STOP;
			end
		end
		return r;
	endfunction

endpackage

// ----- design/acd_store_step.sv -----
// One payload store: keeps the byte if room remains, captures the prefix,
// and feeds the number parser once a CS: or NAV: prefix is complete.
module acd_store_step #(
	parameter int PAYLOAD_MAX = acd_pkg::PAYLOAD_MAX_DEF,
	parameter int CNT_W       = $clog2(PAYLOAD_MAX + 1)
) (
	input  logic                 en,
	input  logic [7:0]           data,
	input  logic [CNT_W-1:0]     cnt_in,
	input  acd_pkg::prefix_t     pfx_in,
	input  acd_pkg::num_state_t  num_in,
	output logic [CNT_W-1:0]     cnt_out,
	output acd_pkg::prefix_t     pfx_out,
	output acd_pkg::num_state_t  num_out
);

	always_comb begin
		cnt_out = cnt_in;
		pfx_out = pfx_in;
		num_out = num_in;
		if (en && cnt_in < CNT_W'(PAYLOAD_MAX)) begin
			for (int i = 0; i < 4; i++) begin
				if (cnt_in == CNT_W'(i)) begin
					pfx_out[i] = data;
				end
			end
			cnt_out = cnt_in + 1'b1;
			if ((cnt_in >= CNT_W'(3) && acd_pkg::pfx_is_cs(pfx_out)) ||
			    (cnt_in >= CNT_W'(4) && acd_pkg::pfx_is_nav(pfx_out))) begin
				num_out = acd_pkg::parse_byte(num_in, data);
			end
		end
	end

endmodule

// ----- design/acd_event_gen.sv -----
// Classifies the closed frame from its kept prefix and forms the value.
module acd_event_gen #(
	parameter int CNT_W = 8
) (
	input  logic [CNT_W-1:0]     cnt,
	input  acd_pkg::prefix_t     pfx,
	input  acd_pkg::num_state_t  num,
	output acd_pkg::event_kind_t kind,
	output logic [31:0]          value
);

	logic        has3;
	logic        has4;
	logic [31:0] num_val;

	assign has3 = cnt >= CNT_W'(3);
	assign has4 = cnt >= CNT_W'(4);

	// magnitude never exceeds 2^31, so bit 31 alone marks the positive clamp
	assign num_val = num.negative ? (32'd0 - num.accum) :
	                 (num.accum[31] ? acd_pkg::VALUE_MAX : num.accum);

	always_comb begin
		kind  = acd_pkg::EV_UNKNOWN;
		value = 32'd0;
		if (has3 && acd_pkg::pfx_is_ps(pfx)) begin
			kind = acd_pkg::EV_PROMPT;
		end else if (has3 && acd_pkg::pfx_is_cs(pfx)) begin
			kind  = acd_pkg::EV_COMMAND;
			value = num_val;
		end else if (has4 && acd_pkg::pfx_is_nav(pfx)) begin
			kind  = acd_pkg::EV_NAV;
			value = num_val;
		end
	end

endmodule

// ----- design/apc_command_deframer_core.sv -----
// APC command deframer. Takes one terminal output byte per transfer and
// watches for ESC _ payload ESC \ frames; on each frame close it emits one
// event (prompt start, command start with number, history navigate with
// number, or unrecognised). Throughput is one byte per clock while not
// stalled: a byte is registered on input, the whole frame and number state
// is updated from it, and any event lands in the result register. The
// input side stalls only when a frame closes while the result register
// still holds an event that has not been taken. At most PAYLOAD_MAX
// payload bytes are kept; the rest are dropped.
`include "apc_command_deframer_core_assert.svh"

module apc_command_deframer_core #(
	parameter int PAYLOAD_MAX = acd_pkg::PAYLOAD_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] event_value
	output logic [1:0]  m_axis_tuser    // [1:0] event_kind
);

	localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 adv;

	acd_pkg::frame_phase_t phase_q, phase_d;
	logic [CNT_W-1:0]     cnt_q, cnt_a, cnt_b;
	acd_pkg::prefix_t     pfx_q, pfx_a, pfx_b;
	acd_pkg::num_state_t  num_q, num_a, num_b;

	logic                 en_a, en_b, start, emit;
	logic [7:0]           byte_a;

	acd_pkg::event_kind_t ev_kind;
	logic [31:0]          ev_value;

	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	logic [31:0]          out_value_q;

	// input register
	assign adv           = valid_s1 && !(emit && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// frame sequencing; ESC + other byte inside a payload stores two bytes
	always_comb begin
		phase_d = phase_q;
		en_a    = 1'b0;
		en_b    = 1'b0;
		byte_a  = byte_s1;
		start   = 1'b0;
		emit    = 1'b0;
		case (phase_q)
			acd_pkg::FR_IDLE: begin
				if (byte_s1 == acd_pkg::CH_ESC) phase_d = acd_pkg::FR_ESC;
			end
			acd_pkg::FR_ESC: begin
				if (byte_s1 == acd_pkg::CH_APC) begin
					phase_d = acd_pkg::FR_PAYLOAD;
					start   = 1'b1;
				end else if (byte_s1 != acd_pkg::CH_ESC) begin
					phase_d = acd_pkg::FR_IDLE;
				end
			end
			acd_pkg::FR_PAYLOAD: begin
				if (byte_s1 == acd_pkg::CH_ESC) begin
					phase_d = acd_pkg::FR_PESC;
				end else begin
					en_a = 1'b1;
				end
			end
			acd_pkg::FR_PESC: begin
				if (byte_s1 == acd_pkg::CH_BSL) begin
					phase_d = acd_pkg::FR_IDLE;
					emit    = 1'b1;
				end else begin
					en_a   = 1'b1;
					byte_a = acd_pkg::CH_ESC;
					if (byte_s1 != acd_pkg::CH_ESC) begin
						en_b    = 1'b1;
						phase_d = acd_pkg::FR_PAYLOAD;
					end
				end
			end
			default: phase_d = acd_pkg::FR_IDLE;
		endcase
	end

	acd_store_step #(.PAYLOAD_MAX(PAYLOAD_MAX), .CNT_W(CNT_W)) u_store_a (
		.en      (en_a),
		.data    (byte_a),
		.cnt_in  (cnt_q),
		.pfx_in  (pfx_q),
		.num_in  (num_q),
		.cnt_out (cnt_a),
		.pfx_out (pfx_a),
		.num_out (num_a)
	);

	acd_store_step #(.PAYLOAD_MAX(PAYLOAD_MAX), .CNT_W(CNT_W)) u_store_b (
		.en      (en_b),
		.data    (byte_s1),
		.cnt_in  (cnt_a),
		.pfx_in  (pfx_a),
		.num_in  (num_a),
		.cnt_out (cnt_b),
		.pfx_out (pfx_b),
		.num_out (num_b)
	);

	acd_event_gen #(.CNT_W(CNT_W)) u_event (
		.cnt   (cnt_q),
		.pfx   (pfx_q),
		.num   (num_q),
		.kind  (ev_kind),
		.value (ev_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= acd_pkg::FR_IDLE;
			cnt_q   <= '0;
			num_q   <= acd_pkg::NUM_CLEAR;
		end else if (adv) begin
			phase_q <= phase_d;
			if (start) begin
				cnt_q <= '0;
				num_q <= acd_pkg::NUM_CLEAR;
			end else begin
				cnt_q <= cnt_b;
				num_q <= num_b;
			end
		end
	end

	// prefix bytes are only read below the count, so no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			pfx_q <= pfx_b;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_kind_q  <= ev_kind;
			out_value_q <= ev_value;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_kind_q;

	`ACD_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(PAYLOAD_MAX))
	`ACD_ASSERT_IMP(a_mag_bound, 1'b1, num_q.accum <= acd_pkg::MAG_LIMIT)
	`ACD_ASSERT_NXT(a_close_loads, adv && emit,
		m_axis_tvalid && phase_q == acd_pkg::FR_IDLE)
	`ACD_ASSERT_NXT(a_stop_sticks, num_q.phase == acd_pkg::NUM_STOP && !(adv && start),
		num_q.phase == acd_pkg::NUM_STOP)
	`ACD_ASSERT_IMP(a_plain_zero, m_axis_tvalid && (m_axis_tuser == acd_pkg::EV_PROMPT ||
		m_axis_tuser == acd_pkg::EV_UNKNOWN), m_axis_tdata == 32'd0)

endmodule
